@@ design/tgg_pkg.sv @@
// Shared types, constants and the sine table function for the tripod gait generator.
package tgg_pkg;

    localparam int PHASE_BITS_DEF   = 32;
    localparam int SINE_ENTRIES_DEF = 256;
    localparam int QUEUE_DEPTH      = 2;

    localparam int TIME_W      = 16;
    localparam int DIR_W       = 16;
    localparam int RATE_W      = 16;
    localparam int ANGLE_CFG_W = 15;
    localparam int STRIDE_W    = 16;
    localparam int ANGLE_W     = 17;
    localparam int LEG_W       = 3;
    localparam int NUM_LEGS    = 6;
    localparam int SINE_W      = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;

    localparam logic [31:0] DIR_THRESHOLD = 32'd10737418;
    localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT = 17'sd46080;
    localparam logic signed [ANGLE_W-1:0] CALF_OFFSET = 17'sd11520;
    localparam logic [17:0] CALF_RECIP = 18'd209716;
    localparam int CALF_SHIFT = 21;

    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1073741824;

    localparam logic [RATE_W-1:0]      WALK_RATE_RST  = 16'd4295;
    localparam logic [ANGLE_CFG_W-1:0] MAX_STRIDE_RST = 15'd7680;
    localparam logic [ANGLE_CFG_W-1:0] TURN_RATE_RST  = 15'd5120;
    localparam logic [ANGLE_CFG_W-1:0] LIFT_ANGLE_RST = 15'd5120;

    // legs 5,1,3 take the base phase, legs 2,4,0 the phase shifted by half a cycle
    localparam logic [LEG_W-1:0] LEG_ORDER [NUM_LEGS] = '{3'd5, 3'd1, 3'd3, 3'd2, 3'd4, 3'd0};
    localparam logic [LEG_W-1:0] GROUP_B_FIRST  = 3'd3;
    localparam logic [LEG_W-1:0] LEFT_FIRST_LEG = 3'd3;
    localparam logic [LEG_W-1:0] LAST_SLOT      = 3'd5;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_WALK_RATE  = 2'd0,
        REG_MAX_STRIDE = 2'd1,
        REG_TURN_RATE  = 2'd2,
        REG_LIFT_ANGLE = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [RATE_W-1:0]      walk_rate;
        logic [ANGLE_CFG_W-1:0] max_stride;
        logic [ANGLE_CFG_W-1:0] turn_rate;
        logic [ANGLE_CFG_W-1:0] lift_angle;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    function automatic logic [SINE_W-1:0] sine_value(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        x2 = (x * x) >> 30;
        t  = ONE_Q30;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd110;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
        return SINE_W'((((x * t) >> 30) + 64'd16384) >> 15);
    endfunction

endpackage

@@ design/tgg_front.sv @@
// Front sequencer: accept a tick, test the command, advance the phase, derive strides.
module tgg_front #(
    parameter int PHASE_BITS = tgg_pkg::PHASE_BITS_DEF,
    parameter int ENTRY_W    = PHASE_BITS + 2 * tgg_pkg::STRIDE_W
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [tgg_pkg::TIME_W-1:0]         delta_time_us,
    input  logic signed [tgg_pkg::DIR_W-1:0]   dir_x,
    input  logic signed [tgg_pkg::DIR_W-1:0]   dir_y,
    input  tgg_pkg::cfg_t                      cfg,
    input  tgg_pkg::qstat_t                    qstat,
    output logic                               push,
    output logic [ENTRY_W-1:0]                 push_data
);
    import tgg_pkg::*;

    localparam int MUL_W  = 17;
    localparam int PROD_W = 2 * MUL_W;
    localparam int SUM_W  = PROD_W - 1;
    localparam int RND_W  = SUM_W - 15;
    localparam logic signed [SUM_W-1:0] STRIDE_BIAS = SUM_W'(16384);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_SQX  = 7'b0000010,
        ST_SQY  = 7'b0000100,
        ST_ADV  = 7'b0001000,
        ST_FWD  = 7'b0010000,
        ST_TRN  = 7'b0100000,
        ST_STR  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [TIME_W-1:0]         dt_reg;
    logic signed [DIR_W-1:0]   dx_reg, dy_reg;
    logic [PHASE_BITS-1:0]     phase_reg, phase_next;
    logic [31:0]               mag_reg, mag_next;
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [PROD_W-1:0]  prod_reg, fwd_reg;
    logic                      prod_load;
    logic signed [SUM_W-1:0]   sum_l, sum_r;
    logic signed [RND_W-1:0]   rnd_l, rnd_r, lim;
    logic signed [STRIDE_W-1:0] stride_l, stride_r;

    function automatic logic signed [STRIDE_W-1:0] clamp_stride(
        input logic signed [RND_W-1:0] v,
        input logic signed [RND_W-1:0] limit
    );
        logic signed [RND_W-1:0] c;
        c = v;
        if (v > limit)
        begin
            c = limit;
        end
        else if (v < -limit)
        begin
            c = -limit;
        end
        return STRIDE_W'(c);
    endfunction

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_SQX:
            begin
                mul_a = MUL_W'(dx_reg);
                mul_b = MUL_W'(dx_reg);
            end
            ST_SQY:
            begin
                mul_a = MUL_W'(dy_reg);
                mul_b = MUL_W'(dy_reg);
            end
            ST_ADV:
            begin
                mul_a = signed'({1'b0, dt_reg});
                mul_b = signed'({1'b0, cfg.walk_rate});
            end
            ST_FWD:
            begin
                mul_a = MUL_W'(dx_reg);
                mul_b = signed'({2'b00, cfg.max_stride});
            end
            ST_TRN:
            begin
                mul_a = MUL_W'(dy_reg);
                mul_b = signed'({2'b00, cfg.turn_rate});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        mag_next   = mag_reg;
        prod_load  = 1'b0;
        push       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SQX;
                end
            end
            ST_SQX:
            begin
                prod_load  = 1'b1;
                state_next = ST_SQY;
            end
            ST_SQY:
            begin
                prod_load  = 1'b1;
                mag_next   = prod_reg[31:0];
                state_next = ST_ADV;
            end
            ST_ADV:
            begin
                prod_load  = 1'b1;
                mag_next   = mag_reg + prod_reg[31:0];
                state_next = ST_FWD;
            end
            ST_FWD:
            begin
                if (mag_reg > DIR_THRESHOLD)
                begin
                    prod_load  = 1'b1;
                    phase_next = phase_reg + prod_reg[PHASE_BITS-1:0];
                    state_next = ST_TRN;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_TRN:
            begin
                prod_load  = 1'b1;
                state_next = ST_STR;
            end
            ST_STR:
            begin
                push = !qstat.full;
                if (!qstat.full)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            dt_reg <= delta_time_us;
            dx_reg <= dir_x;
            dy_reg <= dir_y;
        end
        if (prod_load)
        begin
            prod_reg <= mul_a * mul_b;
        end
        if (state_reg == ST_TRN)
        begin
            fwd_reg <= prod_reg;
        end
        mag_reg <= mag_next;
    end

    assign sum_l = SUM_W'(fwd_reg) + SUM_W'(prod_reg) + STRIDE_BIAS;
    assign sum_r = SUM_W'(fwd_reg) - SUM_W'(prod_reg) + STRIDE_BIAS;
    assign rnd_l = sum_l[SUM_W-1:15];
    assign rnd_r = sum_r[SUM_W-1:15];
    assign lim   = signed'({3'b000, cfg.max_stride});

    assign stride_l  = clamp_stride(rnd_l, lim);
    assign stride_r  = clamp_stride(rnd_r, lim);
    assign push_data = {phase_reg, stride_l, stride_r};

endmodule

@@ design/tgg_queue.sv @@
// Short item queue between the front sequencer and the leg pipeline.
module tgg_queue #(
    parameter int WIDTH = tgg_pkg::PHASE_BITS_DEF + 2 * tgg_pkg::STRIDE_W,
    parameter int DEPTH = tgg_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [WIDTH-1:0]  push_data,
    input  logic              pop,
    output logic [WIDTH-1:0]  pop_data,
    output tgg_pkg::qstat_t   qstat
);
    import tgg_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    always_comb
    begin
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data    = mem[rd_ptr_reg];
    assign qstat.full  = (count_reg == CNT_W'(DEPTH));
    assign qstat.empty = (count_reg == '0);

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !qstat.full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qstat.empty)
        else $error("queue read while empty");

endmodule

@@ design/tgg_back.sv @@
// Leg pipeline: expand one queued tick into six leg joint targets.
module tgg_back #(
    parameter int PHASE_BITS   = tgg_pkg::PHASE_BITS_DEF,
    parameter int SINE_ENTRIES = tgg_pkg::SINE_ENTRIES_DEF,
    parameter int ENTRY_W      = PHASE_BITS + 2 * tgg_pkg::STRIDE_W
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  tgg_pkg::qstat_t                      qstat,
    output logic                                 pop,
    input  logic [ENTRY_W-1:0]                   pop_data,
    input  logic [tgg_pkg::ANGLE_CFG_W-1:0]      lift_angle,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [tgg_pkg::LEG_W-1:0]            leg_number,
    output logic signed [tgg_pkg::ANGLE_W-1:0]   hip_target,
    output logic signed [tgg_pkg::ANGLE_W-1:0]   thigh_target,
    output logic signed [tgg_pkg::ANGLE_W-1:0]   calf_target,
    output logic                                 last_leg
);
    import tgg_pkg::*;

    localparam int IDX_W   = $clog2(SINE_ENTRIES);
    localparam int IP_W    = PHASE_BITS - 1 + IDX_W;
    localparam int RAMP_W  = PHASE_BITS + 1;
    localparam int HPROD_W = STRIDE_W + RAMP_W;
    localparam int HRND_W  = HPROD_W - (PHASE_BITS - 1);
    localparam int LPROD_W = SINE_W + ANGLE_CFG_W;
    localparam int LSUM_W  = LPROD_W + 1;
    localparam int LIFT_W  = LSUM_W - 15;
    localparam int CNUM_W  = 18;
    localparam int CPROD_W = 2 * CNUM_W;
    localparam logic [RAMP_W-1:0] HALF = {2'b01, {(PHASE_BITS - 1){1'b0}}};
    localparam logic signed [HPROD_W-1:0] HIP_BIAS = HPROD_W'(1) << (PHASE_BITS - 2);

    logic [SINE_W-1:0] sine_tab [SINE_ENTRIES];

    for (genvar i = 0; i < SINE_ENTRIES; i++)
    begin : g_sine
        localparam int FOLD = (2 * i > SINE_ENTRIES) ? SINE_ENTRIES - i : i;
        localparam logic [63:0] ANGLE = (PI_Q30 * 64'(FOLD)) / SINE_ENTRIES;
        assign sine_tab[i] = sine_value(ANGLE);
    end

    logic                       active_reg;
    logic [LEG_W-1:0]           k_reg;
    logic [PHASE_BITS-1:0]      cur_phase_reg;
    logic signed [STRIDE_W-1:0] cur_sl_reg, cur_sr_reg;
    logic                       adv, issue;

    logic [LEG_W-1:0]           leg_s0;
    logic [PHASE_BITS-1:0]      phase_s0;
    logic                       left_s0, swing_s0;
    logic [PHASE_BITS-2:0]      r_s0;
    logic signed [RAMP_W-1:0]   ramp_s0;
    logic signed [STRIDE_W-1:0] stride_s0, sstride_s0;
    logic [IP_W-1:0]            idx_prod;
    logic [IDX_W-1:0]           idx_s0;

    logic                       v1_reg, v2_reg, v3_reg, out_valid_reg;
    logic [LEG_W-1:0]           leg1_reg, leg2_reg, leg3_reg, leg_out_reg;
    logic                       last1_reg, last2_reg, last3_reg, last_out_reg;
    logic                       left1_reg, left2_reg, swing1_reg, swing2_reg;
    logic signed [STRIDE_W-1:0] sstride1_reg;
    logic signed [RAMP_W-1:0]   ramp1_reg;
    logic [SINE_W-1:0]          rom1_reg;
    logic signed [HPROD_W-1:0]  hprod2_reg;
    logic [LPROD_W-1:0]         lprod2_reg;

    logic signed [HPROD_W-1:0]  hsum;
    logic signed [HRND_W-1:0]   hrnd, hdir;
    logic signed [ANGLE_W-1:0]  hip_s3;
    logic [LSUM_W-1:0]          lsum;
    logic [LIFT_W-1:0]          lift_s3;
    logic [CNUM_W-1:0]          cnum_s3;
    logic signed [ANGLE_W-1:0]  hip3_reg, hip_out_reg;
    logic [LIFT_W-1:0]          lift3_reg, lift_out_reg;
    logic [CNUM_W-1:0]          cnum3_reg;
    logic [CPROD_W-1:0]         cprod;
    logic signed [ANGLE_W-1:0]  calf_s4, calf_out_reg;

    assign adv   = !out_valid_reg || !out_stall;
    assign issue = active_reg && adv;
    assign pop   = !active_reg && !qstat.empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            k_reg         <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                active_reg <= 1'b1;
                k_reg      <= '0;
            end
            else if (issue)
            begin
                if (k_reg == LAST_SLOT)
                begin
                    active_reg <= 1'b0;
                end
                else
                begin
                    k_reg <= k_reg + 1'b1;
                end
            end
            if (adv)
            begin
                v1_reg        <= issue;
                v2_reg        <= v1_reg;
                v3_reg        <= v2_reg;
                out_valid_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            {cur_phase_reg, cur_sl_reg, cur_sr_reg} <= pop_data;
        end
    end

    always_comb
    begin
        leg_s0     = LEG_ORDER[k_reg];
        phase_s0   = (k_reg >= GROUP_B_FIRST) ?
                     {~cur_phase_reg[PHASE_BITS-1], cur_phase_reg[PHASE_BITS-2:0]} :
                     cur_phase_reg;
        left_s0    = (leg_s0 >= LEFT_FIRST_LEG);
        stride_s0  = left_s0 ? cur_sl_reg : cur_sr_reg;
        swing_s0   = !phase_s0[PHASE_BITS-1];
        r_s0       = phase_s0[PHASE_BITS-2:0];
        ramp_s0    = signed'({1'b0, r_s0, 1'b0} - HALF);
        sstride_s0 = swing_s0 ? stride_s0 : -stride_s0;
        idx_prod   = IP_W'(r_s0) * IP_W'(SINE_ENTRIES);
        idx_s0     = idx_prod[IP_W-1:PHASE_BITS-1];
    end

    always_comb
    begin
        hsum    = hprod2_reg + HIP_BIAS;
        hrnd    = hsum[HPROD_W-1:PHASE_BITS-1];
        hdir    = left2_reg ? hrnd : -hrnd;
        if (hdir > HRND_W'(ANGLE_LIMIT))
        begin
            hip_s3 = ANGLE_LIMIT;
        end
        else if (hdir < -HRND_W'(ANGLE_LIMIT))
        begin
            hip_s3 = -ANGLE_LIMIT;
        end
        else
        begin
            hip_s3 = ANGLE_W'(hdir);
        end
        lsum    = LSUM_W'(lprod2_reg) + LSUM_W'(16384);
        lift_s3 = swing2_reg ? lsum[LSUM_W-1:15] : '0;
        cnum_s3 = CNUM_W'(lift_s3) * CNUM_W'(6) + CNUM_W'(5);
    end

    assign cprod   = CPROD_W'(cnum3_reg) * CPROD_W'(CALF_RECIP);
    assign calf_s4 = signed'(ANGLE_W'(cprod[CPROD_W-1:CALF_SHIFT])) + CALF_OFFSET;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            leg1_reg     <= leg_s0;
            last1_reg    <= (k_reg == LAST_SLOT);
            left1_reg    <= left_s0;
            swing1_reg   <= swing_s0;
            sstride1_reg <= sstride_s0;
            ramp1_reg    <= ramp_s0;
            rom1_reg     <= sine_tab[idx_s0];

            leg2_reg     <= leg1_reg;
            last2_reg    <= last1_reg;
            left2_reg    <= left1_reg;
            swing2_reg   <= swing1_reg;
            hprod2_reg   <= sstride1_reg * ramp1_reg;
            lprod2_reg   <= LPROD_W'(rom1_reg) * LPROD_W'(lift_angle);

            leg3_reg     <= leg2_reg;
            last3_reg    <= last2_reg;
            hip3_reg     <= hip_s3;
            lift3_reg    <= lift_s3;
            cnum3_reg    <= cnum_s3;

            leg_out_reg  <= leg3_reg;
            last_out_reg <= last3_reg;
            hip_out_reg  <= hip3_reg;
            lift_out_reg <= lift3_reg;
            calf_out_reg <= calf_s4;
        end
    end

    assign out_valid    = out_valid_reg;
    assign leg_number   = leg_out_reg;
    assign last_leg     = last_out_reg;
    assign hip_target   = hip_out_reg;
    assign thigh_target = signed'(ANGLE_W'(lift_out_reg));
    assign calf_target  = calf_out_reg;

    a_last_is_final_leg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_leg == (leg_number == LEG_ORDER[NUM_LEGS-1])))
        else $error("last_leg flag does not match the final leg of the tick");

    a_lift_calf_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!thigh_target[ANGLE_W-1] && calf_target >= CALF_OFFSET))
        else $error("thigh negative or calf below its offset");

    a_pop_starts_tick: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (active_reg && k_reg == '0))
        else $error("popped tick did not start at the first leg");

endmodule

@@ design/tripod_gait_generator_unit.sv @@
// Top level of the tripod gait generator: configuration registers and the front/queue/back split.
// A tick with a strong enough steering command (squared magnitude above 0.01) advances the
// gait phase and yields six leg items in the order 5,1,3,2,4,0, the sixth one flagged by
// last_leg; a weak tick is consumed and yields nothing. The front sequencer takes a new tick
// only after its current one is done (in_stall is high outside idle), as the five products
// (three for a weak tick) go through its one shared 17x17 multiplier. The leg pipeline
// loads a queued tick and then issues one leg per cycle while out_stall does not hold it,
// and pops the next tick only after the sixth leg. A two-entry queue lets the front take the next
// tick while results wait on out_stall. Write configuration only while the block is idle.
module tripod_gait_generator_unit #(
    parameter int PHASE_BITS   = tgg_pkg::PHASE_BITS_DEF,
    parameter int SINE_ENTRIES = tgg_pkg::SINE_ENTRIES_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [tgg_pkg::TIME_W-1:0]           delta_time_us,
    input  logic signed [tgg_pkg::DIR_W-1:0]     dir_x,
    input  logic signed [tgg_pkg::DIR_W-1:0]     dir_y,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [tgg_pkg::LEG_W-1:0]            leg_number,
    output logic signed [tgg_pkg::ANGLE_W-1:0]   hip_target,
    output logic signed [tgg_pkg::ANGLE_W-1:0]   thigh_target,
    output logic signed [tgg_pkg::ANGLE_W-1:0]   calf_target,
    output logic                                 last_leg,
    input  logic                                 cfg_wr_en,
    input  logic [tgg_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [tgg_pkg::CFG_DATA_W-1:0]       cfg_wr_data
);
    import tgg_pkg::*;

    localparam int ENTRY_W = PHASE_BITS + 2 * STRIDE_W;

    cfg_t               cfg_reg;
    qstat_t             qstat;
    logic               push, pop;
    logic [ENTRY_W-1:0] push_data, pop_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.walk_rate  <= WALK_RATE_RST;
            cfg_reg.max_stride <= MAX_STRIDE_RST;
            cfg_reg.turn_rate  <= TURN_RATE_RST;
            cfg_reg.lift_angle <= LIFT_ANGLE_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index_t'(cfg_index))
                REG_WALK_RATE:  cfg_reg.walk_rate  <= cfg_wr_data;
                REG_MAX_STRIDE: cfg_reg.max_stride <= cfg_wr_data[ANGLE_CFG_W-1:0];
                REG_TURN_RATE:  cfg_reg.turn_rate  <= cfg_wr_data[ANGLE_CFG_W-1:0];
                REG_LIFT_ANGLE: cfg_reg.lift_angle <= cfg_wr_data[ANGLE_CFG_W-1:0];
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    tgg_front #(
        .PHASE_BITS (PHASE_BITS),
        .ENTRY_W    (ENTRY_W)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .delta_time_us (delta_time_us),
        .dir_x         (dir_x),
        .dir_y         (dir_y),
        .cfg           (cfg_reg),
        .qstat         (qstat),
        .push          (push),
        .push_data     (push_data)
    );

    tgg_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .qstat     (qstat)
    );

    tgg_back #(
        .PHASE_BITS   (PHASE_BITS),
        .SINE_ENTRIES (SINE_ENTRIES),
        .ENTRY_W      (ENTRY_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .qstat        (qstat),
        .pop          (pop),
        .pop_data     (pop_data),
        .lift_angle   (cfg_reg.lift_angle),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .leg_number   (leg_number),
        .hip_target   (hip_target),
        .thigh_target (thigh_target),
        .calf_target  (calf_target),
        .last_leg     (last_leg)
    );

endmodule

@@ dv/tripod_gait_generator_unit_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the tripod gait generator: random and directed ticks, leg checks.
module tripod_gait_generator_unit_tb;
    import tgg_pkg::*;

    localparam int ROM_SIZE = SINE_ENTRIES_DEF;
    localparam longint HALF_CYCLE = 64'sd1 <<< (PHASE_BITS_DEF - 1);

    typedef struct packed {
        logic [TIME_W-1:0] dt;
        logic [DIR_W-1:0]  dx;
        logic [DIR_W-1:0]  dy;
    } tick_t;

    typedef struct packed {
        logic [LEG_W-1:0]   leg;
        logic [ANGLE_W-1:0] hip;
        logic [ANGLE_W-1:0] thigh;
        logic [ANGLE_W-1:0] calf;
        logic               is_last;
    } leg_targets_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [TIME_W-1:0] delta_time_us = '0;
    logic signed [DIR_W-1:0] dir_x = '0;
    logic signed [DIR_W-1:0] dir_y = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [LEG_W-1:0] leg_number;
    logic signed [ANGLE_W-1:0] hip_target;
    logic signed [ANGLE_W-1:0] thigh_target;
    logic signed [ANGLE_W-1:0] calf_target;
    logic last_leg;
    logic cfg_wr_en = 1'b0;
    cfg_index_t cfg_index = REG_WALK_RATE;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    tick_t ticks_pending[$];
    leg_targets_t expected_legs[$];

    logic [31:0] phase_acc = '0;
    logic [RATE_W-1:0] rate_per_us = WALK_RATE_RST;
    logic [ANGLE_CFG_W-1:0] stride_lim = MAX_STRIDE_RST;
    logic [ANGLE_CFG_W-1:0] turn_gain = TURN_RATE_RST;
    logic [ANGLE_CFG_W-1:0] lift_peak = LIFT_ANGLE_RST;

    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;
    bit long_hold_go = 1'b0;
    bit long_hold_done = 1'b0;
    int gap_left = 0;
    int stall_left = 0;
    int hold_left = 0;
    int errors = 0;

    tripod_gait_generator_unit uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .delta_time_us(delta_time_us),
        .dir_x(dir_x),
        .dir_y(dir_y),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .leg_number(leg_number),
        .hip_target(hip_target),
        .thigh_target(thigh_target),
        .calf_target(calf_target),
        .last_leg(last_leg),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wr_data(cfg_wr_data)
    );

    always #1 clk = ~clk;

    function automatic bit is_strong(logic signed [DIR_W-1:0] dx, logic signed [DIR_W-1:0] dy);
        longint mag;
        mag = longint'(dx) * longint'(dx) + longint'(dy) * longint'(dy);
        return mag > longint'(DIR_THRESHOLD);
    endfunction

    function automatic logic [SINE_W-1:0] half_sine(int unsigned idx);
        int unsigned i;
        logic [63:0] ang;
        logic [63:0] sq;
        logic [63:0] acc;
        i = idx;
        if (i >= ROM_SIZE)
            i = ROM_SIZE - 1;
        if (2 * i > ROM_SIZE)
            i = ROM_SIZE - i;
        ang = (PI_Q30 * 64'(i)) / 64'(ROM_SIZE);
        sq = (ang * ang) >> 30;
        acc = ONE_Q30;
        acc = ONE_Q30 - ((sq * acc) >> 30) / 64'd110;
        acc = ONE_Q30 - ((sq * acc) >> 30) / 64'd72;
        acc = ONE_Q30 - ((sq * acc) >> 30) / 64'd42;
        acc = ONE_Q30 - ((sq * acc) >> 30) / 64'd20;
        acc = ONE_Q30 - ((sq * acc) >> 30) / 64'd6;
        return SINE_W'((((ang * acc) >> 30) + 64'd16384) >> 15);
    endfunction

    function automatic logic [ANGLE_W-1:0] sat_angle(longint v);
        longint lim;
        lim = longint'(ANGLE_LIMIT);
        if (v > lim)
            v = lim;
        if (v < -lim)
            v = -lim;
        return v[ANGLE_W-1:0];
    endfunction

    function automatic leg_targets_t leg_pose(logic [LEG_W-1:0] leg, logic [31:0] ph,
                                              longint stride, bit is_last);
        leg_targets_t res;
        longint r;
        longint ramp;
        longint hip;
        longint lift;
        longint calf;
        int unsigned idx;
        r = longint'(ph[30:0]);
        ramp = 2 * r - HALF_CYCLE;
        lift = 0;
        if (!ph[31])
        begin
            idx = int'((r * ROM_SIZE) >>> (PHASE_BITS_DEF - 1));
            hip = (stride * ramp + (64'sd1 <<< 30)) >>> 31;
            lift = (longint'(half_sine(idx)) * longint'(lift_peak) + 16384) >>> 15;
        end
        else
        begin
            hip = (-stride * ramp + (64'sd1 <<< 30)) >>> 31;
        end
        if (leg < LEFT_FIRST_LEG)
            hip = -hip;
        calf = (6 * lift + 5) / 10 + longint'(CALF_OFFSET);
        res.leg = leg;
        res.hip = sat_angle(hip);
        res.thigh = sat_angle(lift);
        res.calf = sat_angle(calf);
        res.is_last = is_last;
        return res;
    endfunction

    function automatic void advance_gait(logic [TIME_W-1:0] dt, logic signed [DIR_W-1:0] dx,
                                         logic signed [DIR_W-1:0] dy);
        logic [31:0] step;
        logic [31:0] pa;
        logic [31:0] pb;
        longint ms;
        longint fwd;
        longint trn;
        longint sl;
        longint sr;
        logic [LEG_W-1:0] leg;
        if (!is_strong(dx, dy))
            return;
        step = 32'(dt) * 32'(rate_per_us);
        phase_acc = phase_acc + step;
        ms = longint'(stride_lim);
        fwd = longint'(dx) * ms;
        trn = longint'(dy) * longint'(turn_gain);
        sl = (fwd + trn + 16384) >>> 15;
        sr = (fwd - trn + 16384) >>> 15;
        sl = (sl > ms) ? ms : ((sl < -ms) ? -ms : sl);
        sr = (sr > ms) ? ms : ((sr < -ms) ? -ms : sr);
        pa = phase_acc;
        pb = phase_acc + 32'h8000_0000;
        for (int k = 0; k < NUM_LEGS; k++)
        begin
            leg = LEG_ORDER[k];
            expected_legs.push_back(leg_pose(leg, (k < 3) ? pa : pb,
                                             (leg >= LEFT_FIRST_LEG) ? sl : sr, k == NUM_LEGS - 1));
        end
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // sender: offer pending ticks, predict on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        bit nv;
        tick_t t;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            delta_time_us <= '0;
            dir_x <= '0;
            dir_y <= '0;
            gap_left = 0;
        end
        else
        begin
            nv = in_valid && in_stall;
            if (in_valid && !in_stall)
                advance_gait(delta_time_us, dir_x, dir_y);
            if (!nv)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (tx_idle_en && $urandom_range(0, 3) == 0)
                    gap_left = $urandom_range(0, 6);
                else if (ticks_pending.size() > 0)
                begin
                    t = ticks_pending.pop_front();
                    delta_time_us <= t.dt;
                    dir_x <= t.dx;
                    dir_y <= t.dy;
                    nv = 1'b1;
                end
            end
            in_valid <= nv;
        end
    end

    // receiver stall: random bursts plus one long hold
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
            hold_left = 0;
        end
        else
        begin
            if (long_hold_go && !long_hold_done)
            begin
                hold_left = 300;
                long_hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (rx_idle_en && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(0, 6);
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // leg monitor
    always @(posedge clk)
    begin
        leg_targets_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_legs.size() == 0)
            begin
                $error("unexpected leg item: leg %0d hip %0d", leg_number, hip_target);
                errors++;
            end
            else
            begin
                e = expected_legs.pop_front();
                check_field("leg_number", int'(e.leg), int'(leg_number));
                check_field("hip_target", int'($signed(e.hip)), int'(hip_target));
                check_field("thigh_target", int'($signed(e.thigh)), int'(thigh_target));
                check_field("calf_target", int'($signed(e.calf)), int'(calf_target));
                check_field("last_leg", int'(e.is_last), int'(last_leg));
            end
        end
    end

    task automatic push_tick(int dt, int dx, int dy);
        tick_t t;
        t.dt = dt[TIME_W-1:0];
        t.dx = dx[DIR_W-1:0];
        t.dy = dy[DIR_W-1:0];
        ticks_pending.push_back(t);
    endtask

    task automatic put_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= val;
        case (idx)
            REG_WALK_RATE:  rate_per_us = val;
            REG_MAX_STRIDE: stride_lim = val[ANGLE_CFG_W-1:0];
            REG_TURN_RATE:  turn_gain = val[ANGLE_CFG_W-1:0];
            REG_LIFT_ANGLE: lift_peak = val[ANGLE_CFG_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_gait_regs(logic [15:0] rate, logic [15:0] stride, logic [15:0] turn,
                                 logic [15:0] lift);
        put_reg(REG_WALK_RATE, rate);
        put_reg(REG_MAX_STRIDE, stride);
        put_reg(REG_TURN_RATE, turn);
        put_reg(REG_LIFT_ANGLE, lift);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic queue_random_ticks(int n);
        int strong_count;
        int sel;
        int dt;
        int dx;
        int dy;
        strong_count = 0;
        while (strong_count < n)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 8)
            begin
                dx = $urandom_range(0, 6000) - 3000;
                dy = $urandom_range(0, 6000) - 3000;
            end
            else if (sel < 16)
            begin
                dx = $urandom_range(3270, 3285) * ($urandom_range(0, 1) ? 1 : -1);
                dy = $urandom_range(0, 120) - 60;
            end
            else
            begin
                dx = $urandom_range(0, 65535);
                dy = $urandom_range(0, 65535);
            end
            sel = $urandom_range(0, 99);
            if (sel < 10)
                dt = 0;
            else if (sel < 20)
                dt = 65535;
            else if (sel < 50)
                dt = $urandom_range(0, 2000);
            else
                dt = $urandom_range(0, 65535);
            push_tick(dt, dx, dy);
            if (is_strong(dx[DIR_W-1:0], dy[DIR_W-1:0]))
                strong_count++;
        end
    endtask

    task automatic drain_legs();
        while (ticks_pending.size() > 0 || in_valid || expected_legs.size() > 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_tick(0, 32767, 0);
        push_tick(65535, -32768, 0);
        push_tick(1000, 0, 32767);
        push_tick(65535, 0, -32768);
        push_tick(0, 0, 0);
        push_tick(12345, 3276, 0);
        push_tick(500, 3277, 0);
        push_tick(500, 0, -3277);
        push_tick(40000, -3276, 0);
        push_tick(65535, -32768, -32768);
        push_tick(65535, 32767, 32767);
        push_tick(20000, 32767, -32768);
        push_tick(30000, -32768, 32767);
        push_tick(1, 16384, 8192);
        push_tick(65535, 1000, -20000);
        for (int i = 0; i < 8; i++)
            push_tick(65535, 20000, 5000);
        drain_legs();

        set_gait_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_random_ticks(25);
        drain_legs();

        set_gait_regs(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        queue_random_ticks(15);
        drain_legs();

        set_gait_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 23040)),
                      16'($urandom_range(0, 23040)), 16'($urandom_range(0, 23040)));
        queue_random_ticks(35);
        long_hold_go = 1'b1;
        drain_legs();

        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        set_gait_regs(16'($urandom_range(0, 65535)), 16'd23040, 16'd23040, 16'd23040);
        queue_random_ticks(35);
        drain_legs();

        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #400000;
        $display("simulation failed");
        $finish;
    end

endmodule
